[design/tksd_pkg.sv]
// ----------------------------------------------------------------------------
// tksd_pkg - shared types and constants for the terminal key sequence decoder
// Key codes, decode phases, widths and the final-byte lookup.
// ----------------------------------------------------------------------------
package tksd_pkg;

  localparam int SEQ_BUFFER_LEN = 8;
  localparam int CSI_CNT_W      = $clog2(SEQ_BUFFER_LEN);
  localparam logic [CSI_CNT_W-1:0] CSI_LAST = CSI_CNT_W'(SEQ_BUFFER_LEN - 1);

  localparam int TMO_W = 16;
  localparam logic [TMO_W-1:0] TMO_RESET = 16'd25;

  typedef logic [3:0] key_t;

  localparam key_t K_CHAR      = 4'd0;
  localparam key_t K_ENTER     = 4'd1;
  localparam key_t K_TAB       = 4'd2;
  localparam key_t K_BACKSPACE = 4'd3;
  localparam key_t K_ESCAPE    = 4'd4;
  localparam key_t K_UP        = 4'd5;
  localparam key_t K_DOWN      = 4'd6;
  localparam key_t K_RIGHT     = 4'd7;
  localparam key_t K_LEFT      = 4'd8;
  localparam key_t K_HOME      = 4'd9;
  localparam key_t K_END       = 4'd10;
  localparam key_t K_DELETE    = 4'd11;
  localparam key_t K_PAGEUP    = 4'd12;
  localparam key_t K_PAGEDOWN  = 4'd13;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_ESC  = 3'd1;
  localparam logic [2:0] PH_SS3  = 3'd2;
  localparam logic [2:0] PH_CSI  = 3'd3;
  localparam logic [2:0] PH_UTF8 = 3'd4;

  localparam logic [7:0] B_TAB   = 8'h09;
  localparam logic [7:0] B_LF    = 8'h0a;
  localparam logic [7:0] B_CR    = 8'h0d;
  localparam logic [7:0] B_BS    = 8'h08;
  localparam logic [7:0] B_DEL   = 8'h7f;
  localparam logic [7:0] B_ESC   = 8'h1b;
  localparam logic [7:0] B_SS3   = 8'h4f;  // 'O'
  localparam logic [7:0] B_CSI   = 8'h5b;  // '['
  localparam logic [7:0] B_TILDE = 8'h7e;

  typedef struct packed {
    logic        valid;
    key_t        key;
    logic [31:0] bytes;
    logic [2:0]  count;
  } result_t;

  function automatic key_t decode_final(input logic [7:0] fin, input logic [7:0] param);
    key_t k;
    k = K_ESCAPE;
    case (fin)
      8'h41:   k = K_UP;     // 'A'
      8'h42:   k = K_DOWN;
      8'h43:   k = K_RIGHT;
      8'h44:   k = K_LEFT;
      8'h48:   k = K_HOME;   // 'H'
      8'h46:   k = K_END;    // 'F'
      B_TILDE: begin
        case (param)
          8'h31, 8'h37: k = K_HOME;
          8'h33:        k = K_DELETE;
          8'h34, 8'h38: k = K_END;
          8'h35:        k = K_PAGEUP;
          8'h36:        k = K_PAGEDOWN;
          default:      k = K_ESCAPE;
        endcase
      end
      default: k = K_ESCAPE;
    endcase
    return k;
  endfunction

  // total length of a UTF-8 sequence from its lead byte
  function automatic logic [2:0] utf8_len(input logic [7:0] b);
    logic [2:0] n;
    if (b inside {[8'hc2:8'hdf]}) n = 3'd2;
    else if (b inside {[8'he0:8'hef]}) n = 3'd3;
    else if (b inside {[8'hf0:8'hf4]}) n = 3'd4;
    else n = 3'd1;
    return n;
  endfunction

endpackage

[design/tksd_decode.sv]
// ----------------------------------------------------------------------------
// tksd_decode - sequence state and single-pass decode step
// Holds the decode phase, CSI and UTF-8 gathering state and the inter-byte
// timer; computes the result of one byte or tick and updates state on step.
// ----------------------------------------------------------------------------
module tksd_decode (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic                     action,
  input  logic [7:0]               data_byte,
  input  logic [tksd_pkg::TMO_W-1:0] timeout,
  output tksd_pkg::result_t        res
);
  import tksd_pkg::*;

  logic [2:0]           phase, phase_next;
  logic [7:0]           first_param, first_param_next;
  logic [CSI_CNT_W-1:0] csi_count, csi_count_next;
  logic [23:0]          utf8_held, utf8_held_next;
  logic [2:0]           utf8_expected, utf8_expected_next;
  logic [2:0]           utf8_got, utf8_got_next;
  logic [TMO_W-1:0]     wait_ticks, wait_ticks_next;

  logic [TMO_W-1:0]     limit;
  logic [TMO_W:0]       wait_inc;
  logic [7:0]           param;
  logic [CSI_CNT_W-1:0] csi_inc;
  logic [31:0]          utf8_bytes;
  logic [2:0]           got_inc;
  logic [2:0]           lead_len;

  always_comb begin
    limit      = (timeout == '0) ? TMO_W'(1) : timeout;
    wait_inc   = {1'b0, wait_ticks} + (TMO_W+1)'(1);
    param      = (csi_count == '0) ? data_byte : first_param;
    csi_inc    = csi_count + CSI_CNT_W'(1);
    utf8_bytes = {8'h00, utf8_held} | ({24'h0, data_byte} << {utf8_got[1:0], 3'b000});
    got_inc    = utf8_got + 3'd1;
    lead_len   = utf8_len(data_byte);

    phase_next         = phase;
    first_param_next   = first_param;
    csi_count_next     = csi_count;
    utf8_held_next     = utf8_held;
    utf8_expected_next = utf8_expected;
    utf8_got_next      = utf8_got;
    wait_ticks_next    = wait_ticks;
    res                = '{valid: 1'b0, key: K_CHAR, bytes: 32'h0, count: 3'd0};

    if (action) begin
      if (phase != PH_IDLE) begin
        if (wait_inc < {1'b0, limit}) begin
          wait_ticks_next = wait_inc[TMO_W-1:0];
        end else begin
          // cut off the open sequence
          phase_next      = PH_IDLE;
          wait_ticks_next = '0;
          res.valid       = 1'b1;
          if (phase == PH_UTF8) begin
            res.key            = K_CHAR;
            res.bytes          = {8'h00, utf8_held};
            res.count          = utf8_got;
            utf8_held_next     = '0;
            utf8_got_next      = '0;
            utf8_expected_next = '0;
          end else begin
            res.key = K_ESCAPE;
          end
        end
      end
    end else begin
      wait_ticks_next = '0;
      case (phase)
        PH_ESC: begin
          if (data_byte == B_SS3) begin
            phase_next = PH_SS3;
          end else if (data_byte == B_CSI) begin
            phase_next       = PH_CSI;
            csi_count_next   = '0;
            first_param_next = '0;
          end else begin
            phase_next = PH_IDLE;
            res.valid  = 1'b1;
            res.key    = K_ESCAPE;
          end
        end
        PH_SS3: begin
          phase_next = PH_IDLE;
          res.valid  = 1'b1;
          res.key    = decode_final(data_byte, data_byte);
        end
        PH_CSI: begin
          first_param_next = param;
          csi_count_next   = csi_inc;
          if (data_byte inside {[8'h41:8'h5a]} || data_byte == B_TILDE ||
              csi_inc >= CSI_LAST) begin
            phase_next     = PH_IDLE;
            csi_count_next = '0;
            res.valid      = 1'b1;
            res.key        = decode_final(data_byte, param);
          end
        end
        PH_UTF8: begin
          if (data_byte[7:6] != 2'b10 || got_inc >= utf8_expected || got_inc >= 3'd4) begin
            phase_next         = PH_IDLE;
            utf8_held_next     = '0;
            utf8_got_next      = '0;
            utf8_expected_next = '0;
            res.valid          = 1'b1;
            res.key            = K_CHAR;
            res.bytes          = utf8_bytes;
            res.count          = got_inc;
          end else begin
            utf8_held_next = utf8_bytes[23:0];
            utf8_got_next  = got_inc;
          end
        end
        default: begin
          phase_next = PH_IDLE;
          case (data_byte)
            B_CR, B_LF: begin
              res.valid = 1'b1;
              res.key   = K_ENTER;
            end
            B_TAB: begin
              res.valid = 1'b1;
              res.key   = K_TAB;
            end
            B_DEL, B_BS: begin
              res.valid = 1'b1;
              res.key   = K_BACKSPACE;
            end
            B_ESC: begin
              phase_next = PH_ESC;
            end
            default: begin
              if (lead_len == 3'd1) begin
                res.valid = 1'b1;
                res.key   = K_CHAR;
                res.bytes = {24'h0, data_byte};
                res.count = 3'd1;
              end else begin
                // open a multi-byte character
                phase_next         = PH_UTF8;
                utf8_held_next     = {16'h0, data_byte};
                utf8_got_next      = 3'd1;
                utf8_expected_next = lead_len;
              end
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      first_param   <= '0;
      csi_count     <= '0;
      utf8_held     <= '0;
      utf8_expected <= '0;
      utf8_got      <= '0;
      wait_ticks    <= '0;
    end else if (step) begin
      phase         <= phase_next;
      first_param   <= first_param_next;
      csi_count     <= csi_count_next;
      utf8_held     <= utf8_held_next;
      utf8_expected <= utf8_expected_next;
      utf8_got      <= utf8_got_next;
      wait_ticks    <= wait_ticks_next;
    end
  end

endmodule

[design/terminal_key_sequence_decoder.sv]
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder - terminal byte stream to key events
// Turns received terminal bytes and millisecond ticks into decoded keys.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carries one item per transfer: action 0 is
// a received data_byte, action 1 is one timer tick (data_byte ignored).
// Output channel: out_valid/out_stall carries one key per transfer: key_code,
// and for characters the bytes (first byte lowest) and their count.
// Configuration: cfg_we writes cfg_wdata to the inter-byte timeout, in ticks.
// Write it only while no sequence is open and the pipeline is empty.
// An item is captured in the input register, decoded by the single decode
// pass and its key captured in the result register. Throughput: one item
// per cycle while no result is held by out_stall, set by the decode pass
// between the registers. Items that complete no sequence produce no output.
// Reset: the decoder returns to idle, the timeout becomes 25 ticks, both
// registers empty. While out_stall holds a result, the input register holds
// its item and in_stall rises once that register is full.
// ----------------------------------------------------------------------------
module terminal_key_sequence_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  key_code,
  output logic [31:0] char_bytes,
  output logic [2:0]  char_count,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import tksd_pkg::*;

  logic             s1_valid;
  logic             s1_action;
  logic [7:0]       s1_byte;
  logic [TMO_W-1:0] timeout;
  logic             advance;
  logic             load;
  result_t          res;

  assign advance  = !out_valid || !out_stall;
  assign load     = !s1_valid || advance;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TMO_RESET;
    end else if (cfg_we) begin
      timeout <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      s1_action <= action;
      s1_byte   <= data_byte;
    end
  end

  tksd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_valid && advance),
    .action    (s1_action),
    .data_byte (s1_byte),
    .timeout   (timeout),
    .res       (res)
  );

  // result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && res.valid) begin
      key_code   <= res.key;
      char_bytes <= res.bytes;
      char_count <= res.count;
    end
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - terminal_key_sequence_decoder testbench
// Sends byte and tick transfers, mostly well-formed escape, CSI, SS3 and UTF-8
// sequences with random content plus noise and broken sequences. A scoreboard
// class mirrors the decoder state and checks every key transfer in order.
// The timeout register is rewritten between phases, and idling moves between
// the two sides.
// ----------------------------------------------------------------------------
module tb;
  import tksd_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int DRAIN_CYCLES    = 4;
  localparam int ITEMS_PER_PHASE = 285;
  localparam int MAX_REPORTS     = 10;
  localparam int TICK_RUN_CAP    = 40;

  localparam logic [7:0] F_UP    = "A";
  localparam logic [7:0] F_DOWN  = "B";
  localparam logic [7:0] F_RIGHT = "C";
  localparam logic [7:0] F_LEFT  = "D";
  localparam logic [7:0] F_HOME  = "H";
  localparam logic [7:0] F_END   = "F";
  localparam logic [7:0] CH_A    = "A";
  localparam logic [7:0] CH_Z    = "Z";
  localparam logic [7:0] CH_ZERO = "0";
  localparam logic [7:0] CH_NINE = "9";
  localparam logic [7:0] CH_SEMI = ";";
  localparam logic [7:0] CH_BANG = "!";

  typedef struct packed {
    key_t        key;
    logic [31:0] bytes;
    logic [2:0]  count;
  } key_event_t;

  class key_scoreboard;
    logic [15:0] timeout_ticks;
    logic [2:0]  dec_phase;
    logic [7:0]  first_param;
    logic [2:0]  csi_count;
    logic [23:0] utf8_held;
    logic [2:0]  utf8_total;
    logic [2:0]  utf8_got;
    logic [15:0] idle_ticks;
    key_event_t  expected_keys[$];
    int          mismatches;

    function new();
      timeout_ticks = TMO_RESET;
      dec_phase     = PH_IDLE;
      first_param   = '0;
      csi_count     = '0;
      idle_ticks    = '0;
      mismatches    = 0;
      clear_utf8();
    endfunction

    function void clear_utf8();
      utf8_held  = '0;
      utf8_total = '0;
      utf8_got   = '0;
    endfunction

    function void push_key(key_t k, logic [31:0] bytes, logic [2:0] count);
      key_event_t ev;
      ev.key   = k;
      ev.bytes = bytes;
      ev.count = count;
      expected_keys.push_back(ev);
    endfunction

    function key_t final_key(logic [7:0] fin, logic [7:0] param);
      case (fin)
        F_UP:    return K_UP;
        F_DOWN:  return K_DOWN;
        F_RIGHT: return K_RIGHT;
        F_LEFT:  return K_LEFT;
        F_HOME:  return K_HOME;
        F_END:   return K_END;
        B_TILDE: begin
          case (param)
            "1", "7": return K_HOME;
            "3":      return K_DELETE;
            "4", "8": return K_END;
            "5":      return K_PAGEUP;
            "6":      return K_PAGEDOWN;
            default:  return K_ESCAPE;
          endcase
        end
        default: return K_ESCAPE;
      endcase
    endfunction

    function logic [2:0] lead_length(logic [7:0] b);
      if (b >= 8'hc2 && b <= 8'hdf) return 3'd2;
      if (b >= 8'he0 && b <= 8'hef) return 3'd3;
      if (b >= 8'hf0 && b <= 8'hf4) return 3'd4;
      return 3'd1;
    endfunction

    // Advance the mirror by one accepted transfer; returns 0 for an idle tick.
    function bit note_input(bit act, logic [7:0] b);
      logic [15:0] lim;
      logic [31:0] acc;
      logic [2:0]  got;
      logic [2:0]  n;
      if (act) begin
        if (dec_phase == PH_IDLE) return 0;
        lim = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
        idle_ticks = idle_ticks + 16'd1;
        if (idle_ticks < lim) return 1;
        idle_ticks = '0;
        if (dec_phase == PH_UTF8) begin
          push_key(K_CHAR, {8'h00, utf8_held}, utf8_got);
          clear_utf8();
        end else begin
          push_key(K_ESCAPE, '0, '0);
        end
        dec_phase = PH_IDLE;
        return 1;
      end

      idle_ticks = '0;
      case (dec_phase)
        PH_ESC: begin
          if (b == B_SS3) begin
            dec_phase = PH_SS3;
          end else if (b == B_CSI) begin
            dec_phase   = PH_CSI;
            csi_count   = '0;
            first_param = '0;
          end else begin
            dec_phase = PH_IDLE;
            push_key(K_ESCAPE, '0, '0);
          end
          return 1;
        end
        PH_SS3: begin
          dec_phase = PH_IDLE;
          push_key(final_key(b, b), '0, '0);
          return 1;
        end
        PH_CSI: begin
          if (csi_count == 3'd0) first_param = b;
          csi_count = csi_count + 3'd1;
          // a full buffer ends the sequence on whatever byte came last
          if ((b >= CH_A && b <= CH_Z) || b == B_TILDE ||
              csi_count >= 3'(SEQ_BUFFER_LEN - 1)) begin
            dec_phase = PH_IDLE;
            csi_count = '0;
            push_key(final_key(b, first_param), '0, '0);
          end
          return 1;
        end
        PH_UTF8: begin
          acc = {8'h00, utf8_held} | ({24'h0, b} << (8 * utf8_got[1:0]));
          got = utf8_got + 3'd1;
          if ((b & 8'hc0) != 8'h80 || got >= utf8_total || got >= 3'd4) begin
            push_key(K_CHAR, acc, got);
            clear_utf8();
            dec_phase = PH_IDLE;
          end else begin
            utf8_held = acc[23:0];
            utf8_got  = got;
          end
          return 1;
        end
        default: ;
      endcase

      dec_phase = PH_IDLE;
      case (b)
        B_CR, B_LF:   push_key(K_ENTER, '0, '0);
        B_TAB:        push_key(K_TAB, '0, '0);
        B_DEL, B_BS:  push_key(K_BACKSPACE, '0, '0);
        B_ESC:        dec_phase = PH_ESC;
        default: begin
          n = lead_length(b);
          if (n == 3'd1) begin
            push_key(K_CHAR, {24'h0, b}, 3'd1);
          end else begin
            dec_phase  = PH_UTF8;
            utf8_held  = {16'h0, b};
            utf8_got   = 3'd1;
            utf8_total = n;
          end
        end
      endcase
      return 1;
    endfunction

    function void note_mismatch(string what, key_event_t want, key_event_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t %s: expected key %0d bytes %h count %0d, got key %0d bytes %h count %0d",
                 $time, what, want.key, want.bytes, want.count,
                 got.key, got.bytes, got.count);
    endfunction

    function void check_result(key_t k, logic [31:0] bytes, logic [2:0] count);
      key_event_t want;
      key_event_t got;
      got.key   = k;
      got.bytes = bytes;
      got.count = count;
      if (expected_keys.size() == 0) begin
        note_mismatch("key with none expected", '0, got);
        return;
      end
      want = expected_keys.pop_front();
      if (want.key !== got.key || want.bytes !== got.bytes || want.count !== got.count)
        note_mismatch("key mismatch", want, got);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  key_code;
  logic [31:0] char_bytes;
  logic [2:0]  char_count;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;

  key_scoreboard keys_sb;
  int            send_gap_pct = 0;
  int            stall_pct = 0;
  int            items_done = 0;
  int unsigned   cycle_count = 0;
  logic [7:0]    opening_bytes [0:21];

  terminal_key_sequence_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .key_code   (key_code),
    .char_bytes (char_bytes),
    .char_count (char_count),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // check the key transfer of this edge, then pick the stall for the next one
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      keys_sb.check_result(key_code, char_bytes, char_count);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_item(input bit act, input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    void'(keys_sb.note_input(act, b));
    items_done++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(1'b1, 8'($urandom_range(255)));
  endtask

  // byte inside a sequence, now and then preceded by a few ticks
  task automatic seq_byte(input logic [7:0] b);
    if ($urandom_range(99) < 8) send_ticks($urandom_range(1, 3));
    send_item(1'b0, b);
  endtask

  function automatic int cutoff_run();
    int n;
    n = (keys_sb.timeout_ticks == 16'd0) ? 1 : int'(keys_sb.timeout_ticks);
    return (n > TICK_RUN_CAP) ? TICK_RUN_CAP : n;
  endfunction

  function automatic logic [7:0] pick_final();
    case ($urandom_range(5))
      0:       return F_UP;
      1:       return F_DOWN;
      2:       return F_RIGHT;
      3:       return F_LEFT;
      4:       return F_HOME;
      default: return F_END;
    endcase
  endfunction

  function automatic logic [7:0] utf8_lead(input int n);
    case (n)
      2:       return 8'($urandom_range(8'hc2, 8'hdf));
      3:       return 8'($urandom_range(8'he0, 8'hef));
      default: return 8'($urandom_range(8'hf0, 8'hf4));
    endcase
  endfunction

  task automatic send_random_sequence();
    int kind;
    int n;
    int i;
    kind = $urandom_range(99);
    if (kind < 15) begin
      seq_byte(8'($urandom_range(8'h20, 8'h7e)));
    end else if (kind < 22) begin
      case ($urandom_range(4))
        0:       seq_byte(B_CR);
        1:       seq_byte(B_LF);
        2:       seq_byte(B_TAB);
        3:       seq_byte(B_DEL);
        default: seq_byte(B_BS);
      endcase
    end else if (kind < 37) begin
      seq_byte(B_ESC);
      seq_byte(B_CSI);
      case ($urandom_range(2))
        0: seq_byte(pick_final());
        1: seq_byte(8'($urandom_range(CH_A, CH_Z)));
        default: begin
          seq_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
          if ($urandom_range(1)) begin
            seq_byte(CH_SEMI);
            seq_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
          end
          seq_byte(B_TILDE);
        end
      endcase
    end else if (kind < 47) begin
      seq_byte(B_ESC);
      seq_byte(B_SS3);
      seq_byte($urandom_range(1) ? pick_final() : 8'($urandom_range(255)));
    end else if (kind < 62) begin
      n = $urandom_range(2, 4);
      seq_byte(utf8_lead(n));
      for (i = 1; i < n; i++) seq_byte(8'h80 | 8'($urandom_range(63)));
    end else if (kind < 70) begin
      // truncated character: cut off by time or by a foreign byte
      n = $urandom_range(2, 4);
      seq_byte(utf8_lead(n));
      for (i = $urandom_range(n - 2); i > 0; i--) seq_byte(8'h80 | 8'($urandom_range(63)));
      if ($urandom_range(1)) send_ticks(cutoff_run());
      else seq_byte(8'($urandom_range(255)));
    end else if (kind < 78) begin
      seq_byte(B_ESC);
      if ($urandom_range(1)) send_ticks(cutoff_run());
      else seq_byte($urandom_range(1) ? CH_BANG : 8'($urandom_range(255)));
    end else if (kind < 84) begin
      // no final: the buffer limit closes it
      seq_byte(B_ESC);
      seq_byte(B_CSI);
      repeat (SEQ_BUFFER_LEN - 1)
        seq_byte($urandom_range(3) == 0 ? CH_SEMI : 8'($urandom_range(CH_ZERO, CH_NINE)));
    end else if (kind < 94) begin
      send_ticks($urandom_range(1, cutoff_run() + 2));
    end else begin
      send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
    end
  endtask

  task automatic drain_keys();
    in_valid <= 1'b0;
    while (keys_sb.expected_keys.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    // close any open sequence first: a final letter ends every phase
    if (keys_sb.dec_phase != PH_IDLE) send_item(1'b0, CH_A);
    drain_keys();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    keys_sb.timeout_ticks = v;
  endtask

  initial begin
    int          p;
    logic [15:0] setting;
    keys_sb = new();
    opening_bytes = '{8'h00, 8'hff, 8'h80, B_CR, B_LF, B_TAB, B_DEL, B_BS,
                      B_ESC, B_SS3, F_HOME,
                      B_ESC, B_CSI, "6", B_TILDE,
                      B_ESC, CH_BANG,
                      8'he2, 8'h82, 8'hac,
                      8'hc3, CH_A};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(1'b1, 8'h00);
    foreach (opening_bytes[i]) send_item(1'b0, opening_bytes[i]);

    for (p = 0; p < 6; p++) begin
      case (p)
        0:       setting = 16'd1;
        1:       setting = 16'hffff;
        2:       setting = 16'd0;
        3:       setting = 16'($urandom_range(2, 8));
        4:       setting = 16'($urandom_range(9, 40));
        default: setting = TMO_RESET;
      endcase
      write_timeout(setting);
      send_gap_pct = (p < 2) ? 30 : (p < 4) ? 82 : 0;
      stall_pct    = (p < 2) ? 82 : (p < 4) ? 30 : 0;
      items_done   = 0;
      while (items_done < ITEMS_PER_PHASE) send_random_sequence();
    end

    drain_keys();
    if (keys_sb.mismatches == 0 && keys_sb.expected_keys.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
